>>> sv/modular_inverse_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular inverse block
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication
`define MI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mi_pkg.sv
// ---------------------------------------------------------------------------
// mi_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mi_pkg;

  // Default operand width
  localparam int unsigned OPERAND_BITS_DEF = 63;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a new item, start the reduction
    logic div_init;    // start a Euclid division r0 / r1
    logic div_step;    // one restoring division step
    logic reduce_end;  // last step of the reduction: r1 takes the remainder
    logic euclid_end;  // last step of a Euclid division: rotate r and u
    logic fix;         // bring u0 below the modulus
    logic emit;        // register the result and pulse valid
  } mi_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic r1_zero;
    logic m_zero;
  } mi_stat_t;

endpackage

>>> sv/mi_datapath.sv
// ---------------------------------------------------------------------------
// mi_datapath
// Remainder and coefficient registers, a radix-2 restoring divider with a
// shift-add accumulator for q * u1, and the final normalization.
// ---------------------------------------------------------------------------
module mi_datapath #(
  parameter int unsigned OPERAND_BITS = mi_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mi_pkg::mi_cmd_t         cmd_i,
  output mi_pkg::mi_stat_t        stat_o,
  input  logic [OPERAND_BITS-1:0] value_i,
  input  logic [OPERAND_BITS-1:0] modulus_i,
  output logic [OPERAND_BITS-1:0] inverse_o,
  output logic                    no_inverse_o,
  output logic                    valid_o
);
  import mi_pkg::*;

  localparam int unsigned N = OPERAND_BITS;
  localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

  logic [N-1:0] mod_q, r0_q, r1_q, u0_q, u1_q;
  logic [N-1:0] rem_q, quo_q, acc_q;
  logic         reduce_q, parity_q, m_zero_q;
  logic [N-1:0] inv_q;
  logic         noinv_q, valid_q;

  logic [N-1:0] divisor;
  logic [N:0]   rem_shift;
  logic         ge;
  logic [N-1:0] rem_d, quo_d, acc_d;
  logic [N-1:0] u0_fix, u0_neg;
  logic         noinv_d;
  logic [N-1:0] inv_d;

  // Restoring division step; quotient bits feed the q * u1 accumulator
  always_comb begin
    divisor   = reduce_q ? mod_q : r1_q;
    rem_shift = {rem_q, quo_q[N-1]};
    ge        = rem_shift >= {1'b0, divisor};
    rem_d     = ge ? N'(rem_shift - {1'b0, divisor}) : rem_shift[N-1:0];
    quo_d     = {quo_q[N-2:0], ge};
    acc_d     = {acc_q[N-2:0], 1'b0} + (ge ? u1_q : '0);
  end

  // Normalization of the final coefficient
  always_comb begin
    u0_fix  = (u0_q >= mod_q) ? (u0_q - mod_q) : u0_q;
    u0_neg  = (u0_q == '0) ? '0 : (mod_q - u0_q);
    noinv_d = m_zero_q || (r0_q != ONE);
    if (noinv_d) begin
      inv_d = '0;
    end else begin
      inv_d = parity_q ? u0_q : u0_neg;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mod_q    <= modulus_i;
      r0_q     <= modulus_i;
      m_zero_q <= (modulus_i == '0);
      quo_q    <= value_i;
      rem_q    <= '0;
      acc_q    <= '0;
      u0_q     <= '0;
      u1_q     <= ONE;
      parity_q <= 1'b0;
      reduce_q <= 1'b1;
    end else begin
      if (cmd_i.div_init) begin
        quo_q <= r0_q;
        rem_q <= '0;
        acc_q <= '0;
      end
      if (cmd_i.div_step) begin
        quo_q <= quo_d;
        rem_q <= rem_d;
        acc_q <= acc_d;
      end
      if (cmd_i.reduce_end) begin
        r1_q     <= rem_d;
        reduce_q <= 1'b0;
      end
      if (cmd_i.euclid_end) begin
        r0_q     <= r1_q;
        r1_q     <= rem_d;
        u0_q     <= u1_q;
        u1_q     <= u0_q + acc_d;
        parity_q <= ~parity_q;
      end
      if (cmd_i.fix) begin
        u0_q <= u0_fix;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      inv_q   <= inv_d;
      noinv_q <= noinv_d;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign stat_o.r1_zero = (r1_q == '0);
  assign stat_o.m_zero  = m_zero_q;
  assign inverse_o      = inv_q;
  assign no_inverse_o   = noinv_q;
  assign valid_o        = valid_q;

endmodule

>>> sv/mi_control.sv
// ---------------------------------------------------------------------------
// mi_control
// Sequencer for the reduction, the Euclid division loop and the final
// normalization; counts the bit steps of each division.
// ---------------------------------------------------------------------------
module mi_control #(
  parameter int unsigned OPERAND_BITS = mi_pkg::OPERAND_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mi_pkg::mi_stat_t  stat_i,
  output mi_pkg::mi_cmd_t   cmd_o
);
  import mi_pkg::*;

  localparam int unsigned CW = $clog2(OPERAND_BITS);
  localparam logic [CW-1:0] LAST = CW'(OPERAND_BITS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_FIX    = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last;

  assign last = (cnt_q == LAST);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last) begin
          cmd_o.reduce_end = 1'b1;
          state_d          = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.r1_zero || stat_i.m_zero) begin
          state_d = S_FIX;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last) begin
          cmd_o.euclid_end = 1'b1;
          state_d          = S_CHECK;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> sv/modular_inverse.sv
// ---------------------------------------------------------------------------
// modular_inverse
// Multiplicative inverse modulo a modulus by the extended Euclidean method.
// ---------------------------------------------------------------------------
// Usage:
//   Drive value_i and modulus_i and raise start while busy is low; the item
//   is taken at that clock edge. busy stays high until the result is ready.
//   The result appears on inverse_o / no_inverse_o, marked by valid_o for
//   exactly one cycle; the receiver cannot stall it and must take it then.
//   no_inverse_o is high, with inverse_o zero, when the gcd of the operands
//   is not one or the modulus is zero.
// Timing (N = OPERAND_BITS, s = number of Euclid quotient steps):
//   Every division, the initial reduction included, runs through one
//   radix-2 restoring divider at one quotient bit per cycle. s stays below
//   about 1.44 * N (about 91 for N = 63). A new item may start in the cycle
//   valid_o is high.
// Reset: rst_ni clears the sequencer and the result strobe; no item is held.
// ---------------------------------------------------------------------------
module modular_inverse #(
  parameter int unsigned OPERAND_BITS = mi_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] value_i,
  input  logic [OPERAND_BITS-1:0] modulus_i,
  output logic                    valid_o,
  output logic [OPERAND_BITS-1:0] inverse_o,
  output logic                    no_inverse_o
);
  import mi_pkg::*;

  `include "modular_inverse_assert.svh"

  mi_cmd_t  cmd;
  mi_stat_t stat;

  // Sequencer
  mi_control #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_control (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // Arithmetic
  mi_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (value_i),
    .modulus_i   (modulus_i),
    .inverse_o   (inverse_o),
    .no_inverse_o(no_inverse_o),
    .valid_o     (valid_o)
  );

  // Checks
  `MI_ASSERT_NOW(a_valid_idle, valid_o, !busy, "result shown while busy")
  `MI_ASSERT_NEXT(a_valid_pulse, valid_o, !valid_o, "result strobe longer than one cycle")
  `MI_ASSERT_NOW(a_noinv_zero, valid_o && no_inverse_o, inverse_o == '0, "nonzero inverse flagged")
  `MI_ASSERT_NEXT(a_start_busy, start && !busy, busy && !valid_o, "accepted item not in work")

endmodule

>>> bench/modular_inverse_checker.sv
// ----------------------------------------------------------------------------
// Modular inverse checker
// Watches the start/busy command channel and the strobed result channel of
// the modular inverse block. For every accepted item it computes the inverse
// by an independent extended Euclid loop, queues it, and compares each result
// field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module modular_inverse_checker #(
  parameter int unsigned W = 63
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  logic [W-1:0]   value_i,
  input  logic [W-1:0]   modulus_i,
  input  logic           valid_i,
  input  logic [W-1:0]   inverse_i,
  input  logic           no_inverse_i,
  output int unsigned    mismatches_o,
  output int unsigned    pending_o,
  output int unsigned    checked_o,
  output int unsigned    no_inverse_seen_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inv_result_t;

  inv_result_t pending_inverses[$];

  // Extended Euclid on unsigned magnitudes; the sign of the value's
  // coefficient alternates, so the step parity decides the final negation.
  function automatic inv_result_t euclid_inverse(logic [W-1:0] value,
                                                 logic [W-1:0] modulus);
    logic [W:0]  rem_prev;
    logic [W:0]  rem_cur;
    logic [W:0]  rem_next;
    logic [W:0]  coef_prev;
    logic [W:0]  coef_cur;
    logic [W:0]  coef_next;
    logic [W:0]  quot;
    logic [W:0]  mod_w;
    int unsigned steps;
    inv_result_t res;
    res   = '0;
    mod_w = {1'b0, modulus};
    steps = 0;
    // No residue range exists for a zero modulus
    if (mod_w == '0) begin
      res.no_inverse = 1'b1;
      return res;
    end
    rem_prev  = mod_w;
    rem_cur   = {1'b0, value} % mod_w;
    coef_prev = '0;
    coef_cur  = (W+1)'(1);
    while (rem_cur != '0) begin
      quot      = rem_prev / rem_cur;
      rem_next  = rem_prev - quot * rem_cur;
      coef_next = coef_prev + quot * coef_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_prev = coef_cur;
      coef_cur  = coef_next;
      steps++;
    end
    // A gcd other than one means no inverse
    if (rem_prev != 1) begin
      res.no_inverse = 1'b1;
      return res;
    end
    coef_prev = coef_prev % mod_w;
    if (steps[0]) begin
      res.inverse = coef_prev[W-1:0];
    end else begin
      coef_next   = (mod_w - coef_prev) % mod_w;
      res.inverse = coef_next[W-1:0];
    end
    return res;
  endfunction

  initial begin
    mismatches_o      = 0;
    pending_o         = 0;
    checked_o         = 0;
    no_inverse_seen_o = 0;
  end

  // Compare results first, then queue the item taken at the same edge,
  // since a result in that cycle belongs to an older item.
  always @(posedge clk_i) begin
    inv_result_t want;
    if (rst_ni) begin
      if (valid_i) begin
        checked_o++;
        if (no_inverse_i) begin
          no_inverse_seen_o++;
        end
        if (pending_inverses.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MAX_REPORTS) begin
            $display("[%0t] unexpected result: inverse=%0d no_inverse=%0b",
                     $realtime, inverse_i, no_inverse_i);
          end
        end else begin
          want = pending_inverses.pop_front();
          if (inverse_i !== want.inverse || no_inverse_i !== want.no_inverse) begin
            mismatches_o++;
            if (mismatches_o <= MAX_REPORTS) begin
              $display("[%0t] mismatch: inverse exp=%0d got=%0d, no_inverse exp=%0b got=%0b",
                       $realtime, want.inverse, inverse_i, want.no_inverse, no_inverse_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        pending_inverses.insert(pending_inverses.size(),
                                euclid_inverse(value_i, modulus_i));
      end
      pending_o = pending_inverses.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Modular inverse testbench
// Drives directed corner items (modulus of one and of zero, zero value,
// value at or above the modulus, full-width operands, a worst-case Fibonacci
// pair) and then random items of mixed shapes, with random gaps between
// transfers. Checking is done by the checker instance; this module makes the
// stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mi_pkg::*;

  localparam int unsigned W            = OPERAND_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned DRAIN_CYCLES = 6000;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned FIB_TOP      = 92;

  typedef logic [W-1:0] operand_t;

  localparam operand_t OP_MAX   = '1;
  localparam operand_t POW2_TOP = operand_t'(1) << (W - 1);

  logic        clk          = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  operand_t    value_i      = '0;
  operand_t    modulus_i    = '0;
  logic        busy;
  logic        valid_o;
  operand_t    inverse_o;
  logic        no_inverse_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned no_inverse_seen;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;

  modular_inverse #(
    .OPERAND_BITS(W)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .modulus_i   (modulus_i),
    .valid_o     (valid_o),
    .inverse_o   (inverse_o),
    .no_inverse_o(no_inverse_o)
  );

  modular_inverse_checker #(
    .W(W)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .value_i          (value_i),
    .modulus_i        (modulus_i),
    .valid_i          (valid_o),
    .inverse_i        (inverse_o),
    .no_inverse_i     (no_inverse_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .no_inverse_seen_o(no_inverse_seen)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one that lands deep in an item
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 4000);
  endfunction

  // Random operand with exactly the given bit length
  function automatic operand_t rand_bits(int unsigned nbits);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    raw = raw & ((64'd1 << nbits) - 64'd1);
    raw[nbits-1] = 1'b1;
    return raw[W-1:0];
  endfunction

  // Fibonacci number k; consecutive pairs force the longest Euclid chains
  function automatic operand_t fib(int unsigned k);
    logic [63:0] prev;
    logic [63:0] cur;
    logic [63:0] nxt;
    prev = 0;
    cur  = 1;
    for (int unsigned i = 1; i < k; i++) begin
      nxt  = prev + cur;
      prev = cur;
      cur  = nxt;
    end
    return cur[W-1:0];
  endfunction

  // Present one item after a gap and hold it until the transfer happens
  task automatic send_item(operand_t value, operand_t modulus, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    value_i   <= value;
    modulus_i <= modulus;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  initial begin
    operand_t    val;
    operand_t    modv;
    operand_t    factor;
    int unsigned shape;
    int unsigned fib_k;
    int unsigned gap;
    int unsigned directed;

    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_item('0, operand_t'(1), pick_gap());
    send_item(OP_MAX, operand_t'(1), pick_gap());
    send_item('0, operand_t'(97), pick_gap());
    send_item(operand_t'(3), operand_t'(7), pick_gap());
    send_item(operand_t'(6), operand_t'(9), pick_gap());
    send_item(operand_t'(10), operand_t'(7), pick_gap());
    send_item(operand_t'(7), operand_t'(7), pick_gap());
    send_item(operand_t'(5), '0, pick_gap());
    send_item('0, '0, pick_gap());
    send_item(OP_MAX, '0, pick_gap());
    send_item(operand_t'(1), OP_MAX, pick_gap());
    send_item(OP_MAX - 1, OP_MAX, pick_gap());
    send_item(OP_MAX, OP_MAX, pick_gap());
    send_item(fib(FIB_TOP - 1), fib(FIB_TOP), pick_gap());
    send_item(fib(FIB_TOP), fib(FIB_TOP - 1), pick_gap());
    send_item(operand_t'(1), operand_t'(2), pick_gap());
    send_item(OP_MAX, operand_t'(2), pick_gap());
    send_item(operand_t'(3), POW2_TOP, pick_gap());
    send_item(OP_MAX, POW2_TOP, pick_gap());
    send_item(POW2_TOP, POW2_TOP + 1, pick_gap());
    send_item(operand_t'(2), OP_MAX - 24, pick_gap());
    directed = items_sent;

    // Random items of several shapes
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      shape = $urandom_range(0, 99);
      if (shape < 35) begin
        val  = operand_t'({$urandom, $urandom});
        modv = operand_t'({$urandom, $urandom});
        if (modv == '0) modv = operand_t'(1);
      end else if (shape < 55) begin
        modv = rand_bits($urandom_range(1, W));
        val  = rand_bits($urandom_range(1, W));
      end else if (shape < 70) begin
        factor = operand_t'($urandom_range(2, 5000));
        val    = factor * operand_t'($urandom_range(0, 1 << 20));
        modv   = factor * operand_t'($urandom_range(1, 1 << 20));
      end else if (shape < 80) begin
        modv = operand_t'($urandom_range(1, 64));
        val  = operand_t'($urandom_range(0, 200));
      end else if (shape < 90) begin
        modv = rand_bits($urandom_range(2, W));
        val  = modv - operand_t'($urandom_range(0, 3));
      end else begin
        fib_k = $urandom_range(2, FIB_TOP - 1);
        val   = fib(fib_k);
        modv  = fib(fib_k + 1);
      end
      // Keep one stretch free of idling
      gap = (n >= 30 && n < 50) ? 0 : pick_gap();
      send_item(val, modv, gap);
    end
    start <= 1'b0;

    // Drain: wait for the last result, then watch for stray strobes
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d directed corners and %0d random of mixed shapes.",
             items_sent, directed, items_sent - directed);
    $display("Checked %0d results, %0d without an inverse, %0d mismatches.",
             checked, no_inverse_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
